FILE: rtl/core/wrp_pkg.sv
// Shared types, constants and arithmetic helpers for the ridged Worley pixel pipeline.
`default_nettype none
package wrp_pkg;

   localparam logic [31:0] FREQ_RESET   = 32'h0100_0000;
   localparam logic [29:0] HASH_X_MUL   = 30'd374761393;
   localparam logic [29:0] HASH_Y_MUL   = 30'd668265263;
   localparam logic [31:0] HASH_MIX_MUL = 32'd1274126177;
   localparam logic [17:0] JIT_X_OFS    = 18'd123;
   localparam logic [17:0] JIT_Y_OFS    = 18'd456;
   localparam logic [16:0] ONE_Q16      = 17'h10000;

   // register indexes (byte address 8*i)
   localparam logic [1:0] REG_SEED     = 2'd0;
   localparam logic [1:0] REG_OFFSET_X = 2'd1;
   localparam logic [1:0] REG_OFFSET_Z = 2'd2;
   localparam logic [1:0] REG_FREQ     = 2'd3;

   localparam int SQRT_STAGES = 8;

   typedef struct packed {
      logic [63:0] seed;
      logic [31:0] off_x;
      logic [31:0] off_z;
      logic [31:0] freq;
   } wrp_cfg_type;

   typedef struct packed {
      logic        valid;
      logic [15:0] cell_x;
      logic [15:0] frac_x;
      logic [15:0] cell_y;
      logic [15:0] frac_y;
   } wrp_world_type;

   typedef struct packed {
      logic             valid;
      logic [8:0][35:0] d2;
   } wrp_dist_type;

   typedef struct packed {
      logic [17:0] rem;
      logic [15:0] root;
   } wrp_sq_type;

   // low 45 bits of a sign-extended coordinate times a hash constant
   function automatic logic [44:0] hash_lane(input logic [17:0] n, input logic [29:0] c);
      logic signed [48:0] p;
      p = $signed(n) * $signed({1'b0, c});
      return p[44:0];
   endfunction

   // xor in the seed and fold by 13; only the low 32 bits feed the final multiply
   function automatic logic [31:0] hash_fold(input logic [44:0] a, input logic [44:0] s);
      logic [44:0] h;
      h = a ^ s;
      return h[31:0] ^ h[44:13];
   endfunction

   // one restoring digit of the integer square root
   function automatic wrp_sq_type sqrt_step(input wrp_sq_type s, input logic [1:0] b);
      logic [19:0] r;
      logic [19:0] t;
      wrp_sq_type  o;
      r = {s.rem, b};
      t = {2'b00, s.root, 2'b01};
      if (r >= t) begin
         o.rem  = 18'(r - t);
         o.root = {s.root[14:0], 1'b1};
      end else begin
         o.rem  = r[17:0];
         o.root = {s.root[14:0], 1'b0};
      end
      return o;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/wrp_csr.sv
// Configuration register bank behind the APB-style port.
`default_nettype none
module wrp_csr (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 psel,
   input  wire logic                 penable,
   input  wire logic                 pwrite,
   input  wire logic [4:0]           paddr,
   input  wire logic [63:0]          pwdata,
   output logic [63:0]               prdata,
   output logic                      pready,
   output wrp_pkg::wrp_cfg_type      cfg
);

   wrp_pkg::wrp_cfg_type cfg_ff, cfg_in;
   logic                 wr;

   assign wr     = psel & penable & pwrite;
   assign pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (paddr[4:3])
            wrp_pkg::REG_SEED:     cfg_in.seed  = pwdata;
            wrp_pkg::REG_OFFSET_X: cfg_in.off_x = pwdata[31:0];
            wrp_pkg::REG_OFFSET_Z: cfg_in.off_z = pwdata[31:0];
            wrp_pkg::REG_FREQ:     cfg_in.freq  = pwdata[31:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.seed  <= 64'd0;
         cfg_ff.off_x <= 32'd0;
         cfg_ff.off_z <= 32'd0;
         cfg_ff.freq  <= wrp_pkg::FREQ_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (paddr[4:3])
         wrp_pkg::REG_SEED:     prdata = cfg_ff.seed;
         wrp_pkg::REG_OFFSET_X: prdata = {32'd0, cfg_ff.off_x};
         wrp_pkg::REG_OFFSET_Z: prdata = {32'd0, cfg_ff.off_z};
         wrp_pkg::REG_FREQ:     prdata = {32'd0, cfg_ff.freq};
         default:               prdata = 64'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

FILE: rtl/core/wrp_world.sv
// Pixel to world position: offset add, frequency multiply, round and saturate.
`default_nettype none
module wrp_world (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 en,
   input  wire wrp_pkg::wrp_cfg_type cfg,
   input  wire logic                 in_valid,
   input  wire logic [7:0]           pixel_x,
   input  wire logic [7:0]           pixel_y,
   output wrp_pkg::wrp_world_type    world
);

   function automatic logic [31:0] round_sat(input logic [64:0] prod, input logic neg);
      logic [40:0] q;
      logic [64:0] up;
      logic [31:0] w;
      up = prod + 65'hFF_FFFF;
      if (!neg) begin
         q = prod[64:24];
         w = (q > 41'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
      end else begin
         q = up[64:24];
         if (q > 41'h8000_0000) q = 41'h8000_0000;
         w = ~q[31:0] + 32'd1;
      end
      return w;
   endfunction

   // stage 1: signed sum and magnitude
   logic signed [32:0] sum_x, sum_y;
   logic        v1_ff;
   logic [32:0] mag_x_ff, mag_x_in, mag_y_ff, mag_y_in;
   logic        neg_x_ff, neg_y_ff;

   assign sum_x = $signed({9'd0, pixel_x, 16'd0}) + $signed({cfg.off_x[31], cfg.off_x});
   assign sum_y = $signed({9'd0, pixel_y, 16'd0}) + $signed({cfg.off_z[31], cfg.off_z});
   assign mag_x_in = sum_x[32] ? (~sum_x + 33'd1) : sum_x;
   assign mag_y_in = sum_y[32] ? (~sum_y + 33'd1) : sum_y;

   // stage 2: scale
   logic        v2_ff;
   logic [64:0] prod_x_ff, prod_x_in, prod_y_ff, prod_y_in;
   logic        neg2_x_ff, neg2_y_ff;

   assign prod_x_in = 65'(mag_x_ff) * 65'(cfg.freq);
   assign prod_y_in = 65'(mag_y_ff) * 65'(cfg.freq);

   // stage 3: floor toward minus infinity and saturate
   logic        v3_ff;
   logic [31:0] wx_ff, wx_in, wy_ff, wy_in;

   assign wx_in = round_sat(prod_x_ff, neg2_x_ff);
   assign wy_in = round_sat(prod_y_ff, neg2_y_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_x_ff  <= mag_x_in;
         mag_y_ff  <= mag_y_in;
         neg_x_ff  <= sum_x[32];
         neg_y_ff  <= sum_y[32];
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
         neg2_x_ff <= neg_x_ff;
         neg2_y_ff <= neg_y_ff;
         wx_ff     <= wx_in;
         wy_ff     <= wy_in;
      end
   end

   assign world.valid  = v3_ff;
   assign world.cell_x = wx_ff[31:16];
   assign world.frac_x = wx_ff[15:0];
   assign world.cell_y = wy_ff[31:16];
   assign world.frac_y = wy_ff[15:0];

endmodule
`default_nettype wire

FILE: rtl/core/wrp_field.sv
// Neighbor cell hashes, feature jitter and squared distances for the 3x3 cells.
`default_nettype none
module wrp_field (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  en,
   input  wire wrp_pkg::wrp_cfg_type  cfg,
   input  wire wrp_pkg::wrp_world_type world,
   output wrp_pkg::wrp_dist_type      dist_sq
);

   logic [3:0]  v_ff;            // stages 4..7
   logic        v8_ff, v9_ff;
   logic [15:0] fx4_ff, fy4_ff, fx5_ff, fy5_ff, fx6_ff, fy6_ff;

   // stage 4: per-coordinate hash products
   logic [2:0][17:0] nx, ny, nxo, nyo;
   logic [2:0][44:0] xa_ff, xa_in, xb_ff, xb_in, ya_ff, ya_in, yb_ff, yb_in;

   // stage 5..9
   logic [8:0][31:0] g1_ff, g1_in, g2_ff, g2_in;
   logic [8:0][31:0] m1_ff, m1_in, m2_ff, m2_in;
   logic [8:0][17:0] ex_ff, ex_in, ey_ff, ey_in;
   logic [8:0][34:0] sx_ff, sx_in, sy_ff, sy_in;
   logic [8:0][35:0] d2_ff, d2_in;

   function automatic logic [16:0] jit(input logic [31:0] m);
      logic [15:0] r;
      r = m[15:0] ^ m[31:16];
      return {1'b0, r} + {16'd0, r[15]};
   endfunction

   function automatic logic [34:0] sq18(input logic [17:0] e);
      logic signed [35:0] p;
      p = $signed(e) * $signed(e);
      return p[34:0];
   endfunction

   for (genvar i = 0; i < 3; i++) begin : g_axis
      assign nx[i]    = {{2{world.cell_x[15]}}, world.cell_x} + 18'(i) - 18'd1;
      assign ny[i]    = {{2{world.cell_y[15]}}, world.cell_y} + 18'(i) - 18'd1;
      assign nxo[i]   = nx[i] + wrp_pkg::JIT_X_OFS;
      assign nyo[i]   = ny[i] + wrp_pkg::JIT_Y_OFS;
      assign xa_in[i] = wrp_pkg::hash_lane(nx[i], wrp_pkg::HASH_X_MUL);
      assign xb_in[i] = wrp_pkg::hash_lane(nxo[i], wrp_pkg::HASH_X_MUL);
      assign ya_in[i] = wrp_pkg::hash_lane(ny[i], wrp_pkg::HASH_Y_MUL);
      assign yb_in[i] = wrp_pkg::hash_lane(nyo[i], wrp_pkg::HASH_Y_MUL);
   end

   for (genvar j = 0; j < 3; j++) begin : g_row
      for (genvar i = 0; i < 3; i++) begin : g_col
         localparam int K = 3 * j + i;
         // offset of the neighbor cell corner, -d*65536
         localparam logic [17:0] BIAS = 18'((1 - i) * 65536);
         localparam logic [17:0] BIAS_Y = 18'((1 - j) * 65536);
         assign g1_in[K] = wrp_pkg::hash_fold(xa_ff[i] ^ ya_ff[j], cfg.seed[44:0]);
         assign g2_in[K] = wrp_pkg::hash_fold(xb_ff[i] ^ yb_ff[j], cfg.seed[44:0]);
         assign m1_in[K] = 32'(g1_ff[K] * wrp_pkg::HASH_MIX_MUL);
         assign m2_in[K] = 32'(g2_ff[K] * wrp_pkg::HASH_MIX_MUL);
         assign ex_in[K] = {2'b00, fx6_ff} + BIAS - {1'b0, jit(m1_ff[K])};
         assign ey_in[K] = {2'b00, fy6_ff} + BIAS_Y - {1'b0, jit(m2_ff[K])};
         assign sx_in[K] = sq18(ex_ff[K]);
         assign sy_in[K] = sq18(ey_ff[K]);
         assign d2_in[K] = {1'b0, sx_ff[K]} + {1'b0, sy_ff[K]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff  <= 4'd0;
         v8_ff <= 1'b0;
         v9_ff <= 1'b0;
      end else if (en) begin
         v_ff  <= {v_ff[2:0], world.valid};
         v8_ff <= v_ff[3];
         v9_ff <= v8_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fx4_ff <= world.frac_x;
         fy4_ff <= world.frac_y;
         fx5_ff <= fx4_ff;
         fy5_ff <= fy4_ff;
         fx6_ff <= fx5_ff;
         fy6_ff <= fy5_ff;
         xa_ff  <= xa_in;
         xb_ff  <= xb_in;
         ya_ff  <= ya_in;
         yb_ff  <= yb_in;
         g1_ff  <= g1_in;
         g2_ff  <= g2_in;
         m1_ff  <= m1_in;
         m2_ff  <= m2_in;
         ex_ff  <= ex_in;
         ey_ff  <= ey_in;
         sx_ff  <= sx_in;
         sy_ff  <= sy_in;
         d2_ff  <= d2_in;
      end
   end

   assign dist_sq.valid = v9_ff;
   assign dist_sq.d2    = d2_ff;

endmodule
`default_nettype wire

FILE: rtl/core/wrp_root.sv
// Minimum of nine distances, pipelined integer square root and ridge output.
`default_nettype none
module wrp_root (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 en,
   input  wire wrp_pkg::wrp_dist_type dist_sq,
   output logic                      out_valid,
   output logic [16:0]               ridge_value
);

   localparam int N = wrp_pkg::SQRT_STAGES;

   function automatic logic [35:0] min3(input logic [35:0] a, input logic [35:0] b,
                                        input logic [35:0] c);
      logic [35:0] m;
      m = (a < b) ? a : b;
      return (c < m) ? c : m;
   endfunction

   // stage 10: three partial minima
   logic             v10_ff;
   logic [2:0][35:0] pm_ff, pm_in;
   logic [35:0]      best;

   for (genvar r = 0; r < 3; r++) begin : g_pm
      assign pm_in[r] = min3(dist_sq.d2[3*r], dist_sq.d2[3*r+1], dist_sq.d2[3*r+2]);
   end

   assign best = min3(pm_ff[0], pm_ff[1], pm_ff[2]);

   // root stages: index 0 holds the minimum, each later index two root digits
   logic                       s_vld_ff [0:N];
   logic                       s_big_ff [0:N];
   logic [31:0]                s_v_ff   [0:N];
   wrp_pkg::wrp_sq_type        s_sq_ff  [0:N];
   wrp_pkg::wrp_sq_type        s_sq_in  [1:N];

   logic        out_valid_ff;
   logic [16:0] ridge_ff, ridge_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         v10_ff      <= 1'b0;
         s_vld_ff[0] <= 1'b0;
      end else if (en) begin
         v10_ff      <= dist_sq.valid;
         s_vld_ff[0] <= v10_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pm_ff       <= pm_in;
         // any distance at or above 1.0 clamps the ridge to zero
         s_big_ff[0] <= (best[35:32] != 4'd0);
         s_v_ff[0]   <= best[31:0];
         s_sq_ff[0]  <= '0;
      end
   end

   for (genvar k = 1; k <= N; k++) begin : g_sqrt
      assign s_sq_in[k] = wrp_pkg::sqrt_step(wrp_pkg::sqrt_step(s_sq_ff[k-1],
                                                                s_v_ff[k-1][31:30]),
                                             s_v_ff[k-1][29:28]);
      always_ff @(posedge clock) begin
         if (reset) begin
            s_vld_ff[k] <= 1'b0;
         end else if (en) begin
            s_vld_ff[k] <= s_vld_ff[k-1];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            s_big_ff[k] <= s_big_ff[k-1];
            s_v_ff[k]   <= {s_v_ff[k-1][27:0], 4'd0};
            s_sq_ff[k]  <= s_sq_in[k];
         end
      end
   end

   assign ridge_in = s_big_ff[N] ? 17'd0 : (wrp_pkg::ONE_Q16 - {1'b0, s_sq_ff[N].root});

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= s_vld_ff[N];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ridge_ff <= ridge_in;
      end
   end

   assign out_valid   = out_valid_ff;
   assign ridge_value = ridge_ff;

endmodule
`default_nettype wire

FILE: rtl/core/worley_ridge_noise_pixel.sv
// Ridged Worley noise, one pixel per beat.
// An accepted input beat passes through the world, field and root stages to its result beat.
// Throughput: one pixel per cycle; the pipeline advances whenever the result register is free.
// A stalled result holds the whole pipeline in place, so nothing is lost or repeated.
// Reset (synchronous) clears all valid bits and loads the register defaults.
`default_nettype none
module worley_ridge_noise_pixel (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_pixel_x,
   input  wire logic [7:0]  req_pixel_y,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [16:0]      rsp_ridge_value,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [63:0] pwdata,
   output logic [63:0]      prdata,
   output logic             pready
);

   wrp_pkg::wrp_cfg_type   cfg;
   wrp_pkg::wrp_world_type world;
   wrp_pkg::wrp_dist_type  dist_sq;
   logic                   en;

   // hold every stage while the result beat waits
   assign req_stall = rsp_valid & rsp_stall;
   assign en        = ~req_stall;

   wrp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   wrp_world u_world (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .cfg      (cfg),
      .in_valid (req_valid),
      .pixel_x  (req_pixel_x),
      .pixel_y  (req_pixel_y),
      .world    (world)
   );

   wrp_field u_field (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .cfg     (cfg),
      .world   (world),
      .dist_sq (dist_sq)
   );

   wrp_root u_root (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .dist_sq     (dist_sq),
      .out_valid   (rsp_valid),
      .ridge_value (rsp_ridge_value)
   );

`ifndef SYNTHESIS
   a_ridge_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_ridge_value <= wrp_pkg::ONE_Q16))
      else $error("ridge value above 1.0");

   a_reset_empty: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_freq_write: assert property (@(posedge clock) disable iff (reset)
      (psel && penable && pwrite && (paddr[4:3] == wrp_pkg::REG_FREQ))
      |=> (cfg.freq == $past(pwdata[31:0])))
      else $error("frequency register write lost");
`endif

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking testbench for the ridged Worley noise pixel pipeline.
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY     = 20;
   localparam int IDLE_LIMIT  = 20000;
   localparam int NUM_RANDOM  = 850;
   localparam int GRID        = 256;

   typedef struct packed {
      logic [7:0] px;
      logic [7:0] py;
   } pixel_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_pixel_x = '0;
   logic [7:0]  req_pixel_y = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [16:0] rsp_ridge_value;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [63:0] pwdata = '0;
   logic [63:0] prdata;
   logic        pready;

   worley_ridge_noise_pixel i_dut (
      .clock, .reset, .req_valid, .req_stall, .req_pixel_x, .req_pixel_y,
      .rsp_valid, .rsp_stall, .rsp_ridge_value,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   always #5 clock = ~clock;

   // shadow copy of the register file
   logic [63:0] seed_q;
   logic [31:0] off_x_q;
   logic [31:0] off_z_q;
   logic [31:0] freq_q;

   pixel_type   pixel_queue[$];
   logic [16:0] ridge_queue[$];
   int          error_count = 0;
   int          idle_cycles = 0;
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   bit          hold_rsp = 1'b0;

   // sampled handshake state from the last rising edge
   logic req_stall_s = 1'b0;
   logic req_fire;
   assign req_fire = req_valid && !req_stall;

   task automatic report_mismatch(input string what, input logic [16:0] got,
                                  input logic [16:0] want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic logic [31:0] scale_axis(input logic [7:0] pix, input logic [31:0] off,
                                              input logic [31:0] freq);
      longint sum;
      logic [63:0] mag;
      logic [63:0] prod;
      logic [63:0] q;
      sum = longint'(pix % GRID) * 65536 + longint'($signed(off));
      mag = (sum < 0) ? 64'(-sum) : 64'(sum);
      prod = mag * {32'd0, freq};
      if (sum >= 0) begin
         q = prod >> 24;
         if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
         return q[31:0];
      end else begin
         q = (prod + 64'hFF_FFFF) >> 24;
         if (q > 64'h8000_0000) q = 64'h8000_0000;
         return 32'(-q);
      end
   endfunction

   function automatic longint cell_jitter(input longint cx, input longint cy);
      logic [63:0] h;
      h = (64'(cx) * 64'd374761393) ^ (64'(cy) * 64'd668265263) ^ seed_q;
      h = (h ^ (h >> 13)) * 64'd1274126177;
      h = (h ^ (h >> 16)) & 64'hFFFF;
      return longint'(h) + ((h >= 64'd32768) ? 1 : 0);
   endfunction

   function automatic logic [16:0] ridge_of(input pixel_type p);
      logic [31:0] wx;
      logic [31:0] wz;
      longint cx, cy, fx, fy, ex, ey, nx, ny;
      logic [63:0] best;
      logic [63:0] d2;
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] bitv;
      wx = scale_axis(p.px, off_x_q, freq_q);
      wz = scale_axis(p.py, off_z_q, freq_q);
      cx = longint'($signed(wx[31:16]));
      cy = longint'($signed(wz[31:16]));
      fx = longint'(wx[15:0]);
      fy = longint'(wz[15:0]);
      best = 64'd100 << 32;
      for (int dy = -1; dy <= 1; dy++) begin
         for (int dx = -1; dx <= 1; dx++) begin
            nx = cx + dx;
            ny = cy + dy;
            ex = fx - longint'(dx) * 65536 - cell_jitter(nx, ny);
            ey = fy - longint'(dy) * 65536 - cell_jitter(nx + 123, ny + 456);
            d2 = 64'(ex * ex) + 64'(ey * ey);
            if (d2 < best) best = d2;
         end
      end
      v = best;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      if (res > 64'd65536) res = 64'd65536;
      return 17'(64'd65536 - res);
   endfunction

   task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
      @(negedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {idx, 3'b000}; pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         wrp_pkg::REG_SEED:     seed_q = value;
         wrp_pkg::REG_OFFSET_X: off_x_q = value[31:0];
         wrp_pkg::REG_OFFSET_Z: off_z_q = value[31:0];
         default:               freq_q = value[31:0];
      endcase
   endtask

   task automatic drain_pipeline();
      while (pixel_queue.size() != 0 || ridge_queue.size() != 0) @(negedge clock);
      repeat (LATENCY + 5) @(negedge clock);
   endtask

   // driver: offer the head of the pending queue, hold it while stalled
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall_s) begin
            pixel_queue.pop_front();
         end
         if ((!req_valid || !req_stall_s) && pixel_queue.size() != 0
             && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_pixel_x <= pixel_queue[0].px;
            req_pixel_y <= pixel_queue[0].py;
         end else if (!req_valid || !req_stall_s) begin
            req_valid <= 1'b0;
         end
         rsp_stall <= hold_rsp || ($urandom_range(99) < stall_pct);
      end
   end

   // monitor: predict on accepted inputs, compare on accepted results
   always @(posedge clock) begin
      req_stall_s <= req_stall;
      if (!reset) begin
         if (req_fire) begin
            ridge_queue.insert(ridge_queue.size(), ridge_of('{req_pixel_x, req_pixel_y}));
         end
         if (rsp_valid && !rsp_stall) begin
            if (ridge_queue.size() == 0) begin
               report_mismatch("unexpected beat", rsp_ridge_value, '0);
            end else begin
               if (rsp_ridge_value !== ridge_queue[0])
                  report_mismatch("ridge_value", rsp_ridge_value, ridge_queue[0]);
               ridge_queue.pop_front();
            end
         end
         if (req_fire || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   task automatic add_pixel(input logic [7:0] x, input logic [7:0] y);
      pixel_queue.insert(pixel_queue.size(), pixel_type'{x, y});
   endtask

   task automatic add_random(input int n);
      for (int i = 0; i < n; i++) add_pixel(8'($urandom), 8'($urandom));
   endtask

   initial begin
      seed_q = '0; off_x_q = '0; off_z_q = '0; freq_q = wrp_pkg::FREQ_RESET;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: the four grid corners and two interior pixels at reset settings
      add_pixel(8'd0, 8'd0);
      add_pixel(8'd255, 8'd255);
      add_pixel(8'd0, 8'd255);
      add_pixel(8'd255, 8'd0);
      add_pixel(8'hAA, 8'h55);
      add_pixel(8'h55, 8'hAA);
      drain_pipeline();

      // saturate positive and negative world positions
      write_reg(wrp_pkg::REG_FREQ, 64'hFFFF_FFFF);
      write_reg(wrp_pkg::REG_OFFSET_X, 64'h7FFF_FFFF);
      write_reg(wrp_pkg::REG_OFFSET_Z, 64'h8000_0000);
      write_reg(wrp_pkg::REG_SEED, 64'hFFFF_FFFF_FFFF_FFFF);
      add_pixel(8'd0, 8'd0);
      add_pixel(8'd255, 8'd255);
      add_pixel(8'd17, 8'd200);
      drain_pipeline();

      // zero frequency collapses every pixel to the origin
      write_reg(wrp_pkg::REG_FREQ, 64'd0);
      write_reg(wrp_pkg::REG_OFFSET_X, 64'h0000_0000);
      write_reg(wrp_pkg::REG_OFFSET_Z, 64'hFFFF_FFFF);
      add_pixel(8'd3, 8'd250);
      add_pixel(8'd255, 8'd0);
      drain_pipeline();

      // fine frequency: distances can exceed one, output reaches zero
      write_reg(wrp_pkg::REG_FREQ, 64'h0004_0000);
      write_reg(wrp_pkg::REG_SEED, 64'h0123_4567_89AB_CDEF);
      write_reg(wrp_pkg::REG_OFFSET_X, 64'hFFF0_0000);
      add_random(8);
      drain_pipeline();

      // random phases with random settings and idling patterns
      for (int ph = 0; ph < 5; ph++) begin
         write_reg(wrp_pkg::REG_SEED, {$urandom, $urandom});
         write_reg(wrp_pkg::REG_OFFSET_X, 64'($urandom));
         write_reg(wrp_pkg::REG_OFFSET_Z, 64'($urandom));
         write_reg(wrp_pkg::REG_FREQ,
                   (ph == 4) ? 64'($urandom) : 64'($urandom_range(32'h0800_0000)));
         case (ph)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 84; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 84; end
            3: begin send_idle_pct = 29; stall_pct = 29; end
            default: begin send_idle_pct = 0; stall_pct = 10; end
         endcase
         if (ph == 0) begin
            // long hold-off on results so the pipeline backs up into the input
            hold_rsp = 1'b1;
            add_random(NUM_RANDOM / 5);
            repeat (200) @(negedge clock);
            hold_rsp = 1'b0;
         end else begin
            add_random(NUM_RANDOM / 5);
         end
         drain_pipeline();
      end

      send_idle_pct = 0;
      stall_pct = 0;
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
`default_nettype wire
